/* rtl/core/rpsmp_pkg.sv */
package rpsmp_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int DIGIT_LIMIT_DEF = 19;

    // result kinds
    localparam logic [2:0] KIND_CHAN = 3'd0;
    localparam logic [2:0] KIND_PAY  = 3'd1;
    localparam logic [2:0] KIND_DONE = 3'd2;
    localparam logic [2:0] KIND_ERR  = 3'd3;
    localparam logic [2:0] KIND_INC  = 3'd4;

    // parser phases: header star, count line, then type/length/data per block
    localparam logic [3:0] PH_STAR    = 4'd0;
    localparam logic [3:0] PH_COUNT   = 4'd1;
    localparam logic [3:0] PH_B0_TYPE = 4'd2;
    localparam logic [3:0] PH_B0_LEN  = 4'd3;
    localparam logic [3:0] PH_B0_DATA = 4'd4;
    localparam logic [3:0] PH_B1_TYPE = 4'd5;
    localparam logic [3:0] PH_B1_LEN  = 4'd6;
    localparam logic [3:0] PH_B1_DATA = 4'd7;
    localparam logic [3:0] PH_B2_TYPE = 4'd8;
    localparam logic [3:0] PH_B2_LEN  = 4'd9;
    localparam logic [3:0] PH_B2_DATA = 4'd10;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [7:0] NUM_MAX   = 8'd255;
    localparam logic [7:0] COUNT_REQ = 8'd3;
    localparam logic [3:0] WORD_LEN  = 4'd7;

    localparam int BUF_DEPTH = 4;
    localparam int BUF_PTR_W = $clog2(BUF_DEPTH);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] consumed;
        logic        last;
    } rpsmp_result_t;

    typedef struct packed {
        logic          prim_valid;
        logic          inc_valid;
        rpsmp_result_t prim_res;
        rpsmp_result_t inc_res;
    } rpsmp_push_t;

    function automatic logic [7:0] word_lower(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6D; // m
            3'd1:    c = 8'h65; // e
            3'd2:    c = 8'h73; // s
            3'd3:    c = 8'h73; // s
            3'd4:    c = 8'h61; // a
            3'd5:    c = 8'h67; // g
            3'd6:    c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] word_upper(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h4D; // M
            3'd1:    c = 8'h45; // E
            3'd2:    c = 8'h53; // S
            3'd3:    c = 8'h53; // S
            3'd4:    c = 8'h41; // A
            3'd5:    c = 8'h47; // G
            3'd6:    c = 8'h45; // E
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/rpsmp_parse.sv */
module rpsmp_parse #(
    parameter int COUNT_WIDTH = rpsmp_pkg::COUNT_WIDTH_DEF,
    parameter int DIGIT_LIMIT = rpsmp_pkg::DIGIT_LIMIT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [7:0]           in_byte,
    input  logic                 in_eod,
    output rpsmp_pkg::rpsmp_push_t push
);

    localparam int LPW = $clog2(DIGIT_LIMIT + 1);

    logic [3:0]             phase_reg,      phase_next;
    logic [3:0]             word_idx_reg,   word_idx_next;
    logic [7:0]             num_val_reg,    num_val_next;
    logic                   num_neg_reg,    num_neg_next;
    logic                   num_stop_reg,   num_stop_next;
    logic                   nonempty_reg,   nonempty_next;
    logic                   cr_pend_reg,    cr_pend_next;
    logic                   match_lo_reg,   match_lo_next;
    logic                   match_hi_reg,   match_hi_next;
    logic [COUNT_WIDTH-1:0] byte_cnt_reg,   byte_cnt_next;
    logic [LPW-1:0]         line_pos_reg,   line_pos_next;
    logic                   num_start_reg,  num_start_next;

    logic                   new_line;
    logic                   finished;
    logic                   res_valid;
    logic [2:0]             res_kind;
    logic [7:0]             res_byte;
    logic [15:0]            cons;
    logic                   inc_valid;

    always_comb begin
        logic [COUNT_WIDTH-1:0] cnt_inc;
        logic [31:0]            cnt_wide;
        logic                   is_digit;
        logic                   is_space;
        logic                   do_digit;
        logic [11:0]            prod;
        logic                   num_phase;
        logic                   line_ok;
        logic                   line_err;
        logic [1:0]             blk;

        phase_next     = phase_reg;
        word_idx_next  = word_idx_reg;
        num_val_next   = num_val_reg;
        num_neg_next   = num_neg_reg;
        num_stop_next  = num_stop_reg;
        nonempty_next  = nonempty_reg;
        cr_pend_next   = cr_pend_reg;
        match_lo_next  = match_lo_reg;
        match_hi_next  = match_hi_reg;
        line_pos_next  = line_pos_reg;
        num_start_next = num_start_reg;
        new_line       = 1'b0;
        res_valid      = 1'b0;
        res_kind       = rpsmp_pkg::KIND_ERR;
        res_byte       = 8'd0;

        cnt_inc  = (byte_cnt_reg != {COUNT_WIDTH{1'b1}}) ? byte_cnt_reg + 1'b1 : byte_cnt_reg;
        cnt_wide = 32'(cnt_inc);
        cons     = (cnt_wide > 32'h0000_FFFF) ? 16'hFFFF : cnt_wide[15:0];

        is_digit = (in_byte >= rpsmp_pkg::CH_ZERO) && (in_byte <= rpsmp_pkg::CH_NINE);
        is_space = (in_byte == rpsmp_pkg::CH_SPACE) || (in_byte == rpsmp_pkg::CH_TAB)
                || (in_byte == rpsmp_pkg::CH_LF) || (in_byte == rpsmp_pkg::CH_VT)
                || (in_byte == rpsmp_pkg::CH_FF);
        prod = {1'b0, num_val_reg, 3'b000} + {3'b000, num_val_reg, 1'b0}
             + {4'd0, in_byte - rpsmp_pkg::CH_ZERO};

        num_phase = (phase_reg == rpsmp_pkg::PH_COUNT) || (phase_reg == rpsmp_pkg::PH_B0_LEN)
                 || (phase_reg == rpsmp_pkg::PH_B1_LEN) || (phase_reg == rpsmp_pkg::PH_B2_LEN);

        // number line: result of this byte and the line state it leaves
        line_ok  = cr_pend_reg && (in_byte == rpsmp_pkg::CH_LF) && nonempty_reg;
        line_err = cr_pend_reg && !line_ok;
        do_digit = 1'b0;
        if (num_phase && !cr_pend_reg) begin
            if (in_byte == rpsmp_pkg::CH_CR) begin
                cr_pend_next = 1'b1;
            end else begin
                nonempty_next = 1'b1;
                if (line_pos_reg < LPW'(DIGIT_LIMIT)) begin
                    line_pos_next = line_pos_reg + 1'b1;
                    if (!num_stop_reg) begin
                        if (num_start_reg) begin
                            do_digit = 1'b1;
                        end else if (!is_space) begin
                            num_start_next = 1'b1;
                            if (in_byte == rpsmp_pkg::CH_MINUS) begin
                                num_neg_next = 1'b1;
                            end else if (in_byte != rpsmp_pkg::CH_PLUS) begin
                                do_digit = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        if (do_digit) begin
            if (is_digit) begin
                num_val_next = (prod > 12'(rpsmp_pkg::NUM_MAX)) ? rpsmp_pkg::NUM_MAX : prod[7:0];
            end else begin
                num_stop_next = 1'b1;
            end
        end

        case (phase_reg)
            rpsmp_pkg::PH_B0_TYPE, rpsmp_pkg::PH_B0_LEN, rpsmp_pkg::PH_B0_DATA: blk = 2'd0;
            rpsmp_pkg::PH_B1_TYPE, rpsmp_pkg::PH_B1_LEN, rpsmp_pkg::PH_B1_DATA: blk = 2'd1;
            default:                                                            blk = 2'd2;
        endcase

        unique case (phase_reg)
            rpsmp_pkg::PH_STAR: begin
                if (in_byte == rpsmp_pkg::CH_STAR) begin
                    phase_next = rpsmp_pkg::PH_COUNT;
                    new_line   = 1'b1;
                end else begin
                    res_valid = 1'b1;
                end
            end
            rpsmp_pkg::PH_COUNT: begin
                if (line_err) begin
                    res_valid = 1'b1;
                end else if (line_ok) begin
                    if (!num_neg_reg && num_val_reg == rpsmp_pkg::COUNT_REQ) begin
                        phase_next = rpsmp_pkg::PH_B0_TYPE;
                        new_line   = 1'b1;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
            end
            rpsmp_pkg::PH_B0_TYPE, rpsmp_pkg::PH_B1_TYPE, rpsmp_pkg::PH_B2_TYPE: begin
                if (in_byte == rpsmp_pkg::CH_DOLLAR) begin
                    phase_next = phase_reg + 4'd1;
                    new_line   = 1'b1;
                end else begin
                    res_valid = 1'b1;
                end
            end
            rpsmp_pkg::PH_B0_LEN, rpsmp_pkg::PH_B1_LEN, rpsmp_pkg::PH_B2_LEN: begin
                if (line_err) begin
                    res_valid = 1'b1;
                end else if (line_ok) begin
                    phase_next = phase_reg + 4'd1;
                    new_line   = 1'b1;
                end
            end
            rpsmp_pkg::PH_B0_DATA, rpsmp_pkg::PH_B1_DATA, rpsmp_pkg::PH_B2_DATA: begin
                if (cr_pend_reg) begin
                    if (in_byte != rpsmp_pkg::CH_LF) begin
                        res_valid = 1'b1;
                    end else if (blk == 2'd0) begin
                        if ((match_lo_reg || match_hi_reg) && word_idx_reg == rpsmp_pkg::WORD_LEN) begin
                            phase_next = phase_reg + 4'd1;
                            new_line   = 1'b1;
                        end else begin
                            res_valid = 1'b1;
                        end
                    end else if (blk == 2'd1) begin
                        phase_next = phase_reg + 4'd1;
                        new_line   = 1'b1;
                    end else begin
                        res_valid = 1'b1;
                        res_kind  = rpsmp_pkg::KIND_DONE;
                    end
                end else if (in_byte == rpsmp_pkg::CH_CR) begin
                    cr_pend_next = 1'b1;
                end else if (blk == 2'd0) begin
                    if (word_idx_reg < rpsmp_pkg::WORD_LEN) begin
                        if (in_byte != rpsmp_pkg::word_lower(word_idx_reg[2:0])) begin
                            match_lo_next = 1'b0;
                        end
                        if (in_byte != rpsmp_pkg::word_upper(word_idx_reg[2:0])) begin
                            match_hi_next = 1'b0;
                        end
                        word_idx_next = word_idx_reg + 4'd1;
                    end else begin
                        match_lo_next = 1'b0;
                        match_hi_next = 1'b0;
                    end
                end else begin
                    res_valid = 1'b1;
                    res_kind  = (blk == 2'd1) ? rpsmp_pkg::KIND_CHAN : rpsmp_pkg::KIND_PAY;
                    res_byte  = in_byte;
                end
            end
            default: begin
                res_valid = 1'b1;
            end
        endcase

        byte_cnt_next = cnt_inc;
        inc_valid = in_eod && !(res_valid && (res_kind == rpsmp_pkg::KIND_ERR
                                           || res_kind == rpsmp_pkg::KIND_DONE));
        finished  = in_eod || (res_valid && (res_kind == rpsmp_pkg::KIND_ERR
                                          || res_kind == rpsmp_pkg::KIND_DONE));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= rpsmp_pkg::PH_STAR;
            byte_cnt_reg  <= '0;
            word_idx_reg  <= '0;
            num_val_reg   <= '0;
            num_neg_reg   <= 1'b0;
            num_stop_reg  <= 1'b0;
            nonempty_reg  <= 1'b0;
            cr_pend_reg   <= 1'b0;
            match_lo_reg  <= 1'b1;
            match_hi_reg  <= 1'b1;
            line_pos_reg  <= '0;
            num_start_reg <= 1'b0;
        end else if (in_fire) begin
            if (finished || new_line) begin
                phase_reg     <= finished ? rpsmp_pkg::PH_STAR : phase_next;
                byte_cnt_reg  <= finished ? '0 : byte_cnt_next;
                word_idx_reg  <= '0;
                num_val_reg   <= '0;
                num_neg_reg   <= 1'b0;
                num_stop_reg  <= 1'b0;
                nonempty_reg  <= 1'b0;
                cr_pend_reg   <= 1'b0;
                match_lo_reg  <= 1'b1;
                match_hi_reg  <= 1'b1;
                line_pos_reg  <= '0;
                num_start_reg <= 1'b0;
            end else begin
                phase_reg     <= phase_next;
                byte_cnt_reg  <= byte_cnt_next;
                word_idx_reg  <= word_idx_next;
                num_val_reg   <= num_val_next;
                num_neg_reg   <= num_neg_next;
                num_stop_reg  <= num_stop_next;
                nonempty_reg  <= nonempty_next;
                cr_pend_reg   <= cr_pend_next;
                match_lo_reg  <= match_lo_next;
                match_hi_reg  <= match_hi_next;
                line_pos_reg  <= line_pos_next;
                num_start_reg <= num_start_next;
            end
        end
    end

    always_comb begin
        push.prim_valid        = in_fire && res_valid;
        push.inc_valid         = in_fire && inc_valid;
        push.prim_res.kind     = res_kind;
        push.prim_res.out_byte = res_byte;
        push.prim_res.consumed = cons;
        push.prim_res.last     = !inc_valid;
        push.inc_res.kind      = rpsmp_pkg::KIND_INC;
        push.inc_res.out_byte  = 8'd0;
        push.inc_res.consumed  = cons;
        push.inc_res.last      = 1'b1;
    end

endmodule

/* rtl/core/rpsmp_out_buf.sv */
module rpsmp_out_buf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rpsmp_pkg::rpsmp_push_t  push,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rpsmp_pkg::rpsmp_result_t out_res
);

    localparam int PW = rpsmp_pkg::BUF_PTR_W;

    rpsmp_pkg::rpsmp_result_t mem_reg [rpsmp_pkg::BUF_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    logic [PW-1:0] wr_ptr_2nd;
    logic [PW-1:0] n_push;
    logic          pop;

    // room for the two results one request can cause
    assign room      = count_reg <= (PW+1)'(rpsmp_pkg::BUF_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = PW'(push.prim_valid) + PW'(push.inc_valid);
    assign wr_ptr_2nd = push.prim_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;

    always_ff @(posedge aclk) begin
        if (push.prim_valid) begin
            mem_reg[wr_ptr_reg] <= push.prim_res;
        end
        if (push.inc_valid) begin
            mem_reg[wr_ptr_2nd] <= push.inc_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(n_push) - (PW+1)'(pop);
        end
    end

endmodule

/* rtl/core/resp_pubsub_message_parser.sv */
// channel   dir   ports                               contents
// s_        in    s_tvalid s_tready s_tdata s_tlast   data byte, tlast = end of buffered data
// m_        out   m_tvalid m_tready m_tdata m_tuser   out byte, consumed count, kind
//                 m_tlast                             tlast = final result of a request
//
// one request per cycle while s_tready is high; the parse state is updated in the cycle a byte is taken
// a byte gives zero, one or two results, queued in a four-entry output buffer
// s_tready drops only while the buffer cannot hold two more results
// aresetn is synchronous; afterwards the parser waits for a header star
module resp_pubsub_message_parser #(
    parameter int COUNT_WIDTH = rpsmp_pkg::COUNT_WIDTH_DEF,
    parameter int DIGIT_LIMIT = rpsmp_pkg::DIGIT_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] consumed
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    rpsmp_pkg::rpsmp_push_t   push;
    rpsmp_pkg::rpsmp_result_t res;
    logic                     fire;

    assign fire = s_tvalid && s_tready;

    rpsmp_parse #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DIGIT_LIMIT (DIGIT_LIMIT)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (fire),
        .in_byte (s_tdata),
        .in_eod  (s_tlast),
        .push    (push)
    );

    rpsmp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.consumed, res.out_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
